/* rtl/core/ugrp_pkg.sv */
// Package for the UTF-8 sequence grouper.
// Holds result codes, byte-class masks, the error glyph and the result record type.
// No dependencies.
package ugrp_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int LEN_W   = 3;
  localparam int FILL_W  = 3;
  localparam int REM_W   = 2;
  localparam int PEND_DEPTH = 3;

  localparam logic [KIND_W-1:0] KIND_PASS    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PARTIAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd3;

  localparam logic [BYTE_W-1:0] MASK_ASCII = 8'h80;
  localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hC0;
  localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
  localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;

  localparam logic [BYTE_W-1:0] PAT_CONT  = 8'h80;
  localparam logic [BYTE_W-1:0] PAT_LEAD2 = 8'hC0;
  localparam logic [BYTE_W-1:0] PAT_LEAD3 = 8'hE0;
  localparam logic [BYTE_W-1:0] PAT_LEAD4 = 8'hF0;

  localparam logic [BYTE_W-1:0] GLYPH_B0 = 8'hE2;
  localparam logic [BYTE_W-1:0] GLYPH_B1 = 8'h96;
  localparam logic [BYTE_W-1:0] GLYPH_B2 = 8'h92;
  localparam logic [LEN_W-1:0]  GLYPH_LEN = 3'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
    logic              swal;
  } result_t;

endpackage

/* rtl/core/utf8_sequence_grouper_top.sv */
// UTF-8 sequence grouper, top level.
// One module: byte classification, sequence buffer, output register and skid stage.
// Depends on ugrp_pkg.

// Takes one raw byte per request and returns one result per byte: the byte
// passed through, a swallowed partial sequence, a completed 2- to 4-byte
// sequence, or the error glyph E2 96 92 for a stray continuation or an
// invalid lead byte. Throughput is one byte per clock while in_stall is low;
// the result is registered in the single result register. A skid register
// behind it lets one more byte in while a result is held by out_stall;
// in_stall rises only when both are full. No clearing pass is needed
// after reset.
module utf8_sequence_grouper_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ugrp_pkg::BYTE_W-1:0] raw_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ugrp_pkg::KIND_W-1:0] result_kind,
  output logic [ugrp_pkg::LEN_W-1:0]  out_len,
  output logic [ugrp_pkg::BYTE_W-1:0] out_byte0,
  output logic [ugrp_pkg::BYTE_W-1:0] out_byte1,
  output logic [ugrp_pkg::BYTE_W-1:0] out_byte2,
  output logic [ugrp_pkg::BYTE_W-1:0] out_byte3,
  output logic                     swallowed
);
  import ugrp_pkg::*;

  logic [BYTE_W-1:0] pending [PEND_DEPTH];
  logic [FILL_W-1:0] fill_count, fill_count_next;
  logic [REM_W-1:0]  bytes_remaining, bytes_remaining_next;
  logic              pend_wr;
  logic [1:0]        pend_addr;

  result_t res;
  result_t out_q;
  result_t skid_q;
  logic    skid_valid;
  logic    in_acc;
  logic    out_fire;

  logic [1:0]        fill_cl;
  logic [BYTE_W-1:0] seq [4];

  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  assign fill_cl = (fill_count > FILL_W'(PEND_DEPTH)) ? 2'(PEND_DEPTH) : fill_count[1:0];

  always_comb begin
    for (int i = 0; i < PEND_DEPTH; i++) begin
      seq[i] = (2'(i) < fill_cl) ? pending[i] : '0;
    end
    seq[3] = '0;
    seq[fill_cl] = raw_byte;
  end

  always_comb begin
    res = '0;
    fill_count_next = fill_count;
    bytes_remaining_next = bytes_remaining;
    pend_wr = 1'b0;
    pend_addr = '0;
    if ((raw_byte & MASK_ASCII) == '0) begin
      res.kind = KIND_PASS;
      res.len  = LEN_W'(1);
      res.b0   = raw_byte;
      bytes_remaining_next = '0;
    end else if ((raw_byte & MASK_CONT) == PAT_CONT) begin
      case (bytes_remaining)
        2'd0: begin
          res.kind = KIND_ERROR;
          res.len  = GLYPH_LEN;
          res.b0   = GLYPH_B0;
          res.b1   = GLYPH_B1;
          res.b2   = GLYPH_B2;
        end
        2'd1: begin
          res.kind = KIND_DONE;
          res.len  = LEN_W'(fill_cl) + LEN_W'(1);
          res.b0   = seq[0];
          res.b1   = seq[1];
          res.b2   = seq[2];
          res.b3   = seq[3];
          fill_count_next = FILL_W'(fill_cl) + FILL_W'(1);
          bytes_remaining_next = '0;
        end
        default: begin
          res.kind = KIND_PARTIAL;
          res.swal = 1'b1;
          pend_wr   = (fill_count < FILL_W'(PEND_DEPTH));
          pend_addr = fill_count[1:0];
          fill_count_next = fill_count + FILL_W'(1);
          bytes_remaining_next = bytes_remaining - REM_W'(1);
        end
      endcase
    end else begin
      pend_wr   = 1'b1;
      pend_addr = '0;
      fill_count_next = FILL_W'(1);
      res.kind = KIND_PARTIAL;
      res.swal = 1'b1;
      if ((raw_byte & MASK_LEAD2) == PAT_LEAD2) begin
        bytes_remaining_next = REM_W'(1);
      end else if ((raw_byte & MASK_LEAD3) == PAT_LEAD3) begin
        bytes_remaining_next = REM_W'(2);
      end else if ((raw_byte & MASK_LEAD4) == PAT_LEAD4) begin
        bytes_remaining_next = REM_W'(3);
      end else begin
        bytes_remaining_next = '0;
        res.kind = KIND_ERROR;
        res.len  = GLYPH_LEN;
        res.b0   = GLYPH_B0;
        res.b1   = GLYPH_B1;
        res.b2   = GLYPH_B2;
        res.swal = 1'b0;
      end
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      bytes_remaining <= '0;
    end else if (in_acc) begin
      fill_count <= fill_count_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && pend_wr) begin
      pending[pend_addr] <= raw_byte;
    end
  end

  // result register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid && out_fire) begin
        skid_valid <= 1'b0;
      end else if (in_acc && out_valid && !out_fire) begin
        skid_valid <= 1'b1;
      end
      if (skid_valid) begin
        if (out_fire) begin
          out_valid <= 1'b1;
        end
      end else if (in_acc && (!out_valid || out_fire)) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_acc && (!out_valid || out_fire)) begin
      out_q <= res;
    end
    if (in_acc && out_valid && !out_fire) begin
      skid_q <= res;
    end
  end

  assign result_kind = out_q.kind;
  assign out_len     = out_q.len;
  assign out_byte0   = out_q.b0;
  assign out_byte1   = out_q.b1;
  assign out_byte2   = out_q.b2;
  assign out_byte3   = out_q.b3;
  assign swallowed   = out_q.swal;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output register is empty");

  a_swal_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && swallowed) |-> (out_len == '0 && result_kind == KIND_PARTIAL))
    else $error("swallowed result carries bytes");

  a_error_glyph: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_ERROR) |->
      (out_len == GLYPH_LEN && out_byte0 == GLYPH_B0 && out_byte3 == '0))
    else $error("error result is not the glyph");

  a_open_seq_fill: assert property (@(posedge clk) disable iff (rst)
    (bytes_remaining != '0) |-> (fill_count >= FILL_W'(1) && fill_count <= FILL_W'(PEND_DEPTH)))
    else $error("open sequence with fill count out of range");

  a_done_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_DONE) |-> (out_len >= LEN_W'(2) && out_len <= LEN_W'(4)))
    else $error("completed sequence with bad length");
`endif

endmodule

/* dv/testbench.sv */
// Self-checking testbench for utf8_sequence_grouper_top: directed and random byte streams,
// an in-bench prediction of the sequence grouping, random stalls on both sides.
// Depends on ugrp_pkg and the RTL top level.
`timescale 1ns / 100ps

module testbench;
  import ugrp_pkg::*;

  localparam int BYTE_TARGET = 1900;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int IDLE_PCT    = 26;

  class utf8_group_scoreboard;
    result_t            pending_results[$];
    logic [BYTE_W-1:0]  seq_buf[PEND_DEPTH];
    logic [FILL_W-1:0]  seq_fill;
    logic [REM_W-1:0]   seq_left;
    int                 mismatches;
    int                 checked;
    int                 kind_seen[4];

    function new();
      foreach (seq_buf[i]) seq_buf[i] = '0;
      seq_fill   = '0;
      seq_left   = '0;
      mismatches = 0;
      checked    = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function result_t glyph_result();
      result_t r;
      r      = '0;
      r.kind = KIND_ERROR;
      r.len  = GLYPH_LEN;
      r.b0   = GLYPH_B0;
      r.b1   = GLYPH_B1;
      r.b2   = GLYPH_B2;
      return r;
    endfunction

    // Advance the grouping state by one byte and queue the result it yields.
    function void note_byte(input logic [BYTE_W-1:0] b);
      result_t           r;
      logic [BYTE_W-1:0] seq[4];
      int                n;
      r = '0;
      foreach (seq[i]) seq[i] = '0;
      if ((b & MASK_ASCII) == '0) begin
        seq_left = '0;
        r.kind   = KIND_PASS;
        r.len    = LEN_W'(1);
        r.b0     = b;
      end else if ((b & MASK_CONT) == PAT_CONT) begin
        if (seq_left == 0) begin
          r = glyph_result();
        end else if (seq_left == 1) begin
          n = (seq_fill > PEND_DEPTH) ? PEND_DEPTH : int'(seq_fill);
          for (int i = 0; i < n; i++) seq[i] = seq_buf[i];
          seq[n]   = b;
          seq_fill = FILL_W'(n + 1);
          seq_left = '0;
          r.kind   = KIND_DONE;
          r.len    = LEN_W'(n + 1);
          r.b0     = seq[0];
          r.b1     = seq[1];
          r.b2     = seq[2];
          r.b3     = seq[3];
        end else begin
          if (seq_fill < PEND_DEPTH) seq_buf[seq_fill[1:0]] = b;
          seq_fill = seq_fill + 1'b1;
          seq_left = seq_left - 1'b1;
          r.kind   = KIND_PARTIAL;
          r.swal   = 1'b1;
        end
      end else begin
        seq_buf[0] = b;
        seq_fill   = FILL_W'(1);
        if ((b & MASK_LEAD2) == PAT_LEAD2)      seq_left = REM_W'(1);
        else if ((b & MASK_LEAD3) == PAT_LEAD3) seq_left = REM_W'(2);
        else if ((b & MASK_LEAD4) == PAT_LEAD4) seq_left = REM_W'(3);
        else                                    seq_left = '0;
        if (seq_left == 0) begin
          r = glyph_result();
        end else begin
          r.kind = KIND_PARTIAL;
          r.swal = 1'b1;
        end
      end
      pending_results.push_back(r);
    endfunction

    function string fmt(input result_t r);
      return $sformatf("kind %0d len %0d bytes %h %h %h %h swallowed %0d",
                       r.kind, r.len, r.b0, r.b1, r.b2, r.b3, r.swal);
    endfunction

    function void check_result(input result_t got);
      result_t want;
      checked++;
      kind_seen[got.kind]++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", fmt(got));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind != want.kind || got.len != want.len || got.b0 != want.b0 ||
          got.b1 != want.b1 || got.b2 != want.b2 || got.b3 != want.b3 ||
          got.swal != want.swal) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on result %0d: expected %s, got %s",
                   checked, fmt(want), fmt(got));
      end
    endfunction
  endclass

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] raw_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KIND_W-1:0] result_kind;
  logic [LEN_W-1:0]  out_len;
  logic [BYTE_W-1:0] out_byte0, out_byte1, out_byte2, out_byte3;
  logic              swallowed;

  utf8_group_scoreboard sb = new();
  int cycles   = 0;
  int n_sent   = 0;
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;

  utf8_sequence_grouper_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .raw_byte   (raw_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_kind(result_kind),
    .out_len    (out_len),
    .out_byte0  (out_byte0),
    .out_byte1  (out_byte1),
    .out_byte2  (out_byte2),
    .out_byte3  (out_byte3),
    .swallowed  (swallowed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({result_kind, out_len, out_byte0, out_byte1, out_byte2, out_byte3,
                       swallowed});
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_lead(input int len);
    case (len)
      1: send_byte(8'($urandom_range(8'h00, 8'h7F)));
      2: send_byte(8'($urandom_range(8'hC0, 8'hDF)));
      3: send_byte(8'($urandom_range(8'hE0, 8'hEF)));
      default: send_byte(8'($urandom_range(8'hF0, 8'hF7)));
    endcase
  endtask

  task automatic send_cont();
    send_byte(8'($urandom_range(8'h80, 8'hBF)));
  endtask

  initial begin
    logic [BYTE_W-1:0] directed[];
    int  sel, len, cut;
    bit  held, paused;
    directed = '{
      8'h00, 8'h7F, 8'h80, 8'hBF,             // ascii extremes, stray continuations
      8'hC2, 8'hA9,                           // two-byte sequence
      8'hE2, 8'h82, 8'hAC,                    // three-byte sequence
      8'hF0, 8'h9F, 8'h98, 8'h80,             // four-byte sequence
      8'hF8, 8'hFF,                           // invalid leads
      8'hE2, 8'h41,                           // ascii drops open sequence
      8'hC3, 8'hE2, 8'h82, 8'hAC,             // new lead replaces open one
      8'hF4, 8'hFC, 8'h80                     // invalid lead drops sequence
    };
    held   = 1'b0;
    paused = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_byte(directed[i]);
    wait_drained();

    while (n_sent < BYTE_TARGET) begin
      quiet = (n_sent >= 900 && n_sent < 1200);
      if (!held && n_sent >= 500) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && n_sent >= 1400) begin
        paused = 1'b1;
        wait_drained();
      end
      sel = $urandom_range(99);
      if (sel < 75) begin
        len = $urandom_range(1, 4);
        send_lead(len);
        repeat (len - 1) send_cont();
      end else if (sel < 87) begin
        len = $urandom_range(2, 4);
        cut = $urandom_range(0, len - 2);
        send_lead(len);
        repeat (cut) send_cont();
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("sent %0d bytes, checked %0d results", n_sent, sb.checked);
    $display("pass-through %0d, partial %0d, complete %0d, error glyph %0d, mismatches %0d",
             sb.kind_seen[KIND_PASS], sb.kind_seen[KIND_PARTIAL],
             sb.kind_seen[KIND_DONE], sb.kind_seen[KIND_ERROR], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* utf8_sequence_grouper_top.f */
rtl/core/ugrp_pkg.sv
rtl/core/utf8_sequence_grouper_top.sv
dv/testbench.sv
